FILE: hw/rtl/dsge_pkg.sv
// ----------------------------------------------------------------------------
// dsge_pkg
// Shared types and constants for the sign/magnitude byte delta encoder.
// ----------------------------------------------------------------------------
package dsge_pkg;

  localparam int BYTE_W      = 8;
  localparam int GROUP_MAX   = 8;
  localparam int GROUP_SIZE_DEF = 8;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_packet;
  } item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] coded_byte;
    logic              coded_last;
  } code_t;

  // one stage of the output chain
  typedef struct packed {
    logic              valid;
    logic              last;
    logic [BYTE_W-1:0] data;
  } slot_t;

  // per-cell control from the front end
  typedef struct packed {
    logic capture;
    logic load;
    logic shift;
    logic use_alt;
    logic load_valid;
    logic load_last;
  } cell_ctl_t;

endpackage

FILE: hw/rtl/dsge_cell.sv
// ----------------------------------------------------------------------------
// dsge_cell
// One cell of the group chain: holds one buffered magnitude and one output
// stage that is loaded in parallel and shifts toward the output head.
// ----------------------------------------------------------------------------
module dsge_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  dsge_pkg::cell_ctl_t        ctl,
  input  logic [dsge_pkg::BYTE_W-1:0] delta_in,
  input  logic [dsge_pkg::BYTE_W-1:0] alt_byte,
  input  dsge_pkg::slot_t            up,
  output dsge_pkg::slot_t            slot
);

  logic [dsge_pkg::BYTE_W-1:0] store;
  logic [dsge_pkg::BYTE_W-1:0] data;
  logic                        last;
  logic                        valid;

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      store <= delta_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.load) begin
      valid <= ctl.load_valid;
    end else if (ctl.shift) begin
      valid <= up.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      data <= ctl.use_alt ? alt_byte : store;
      last <= ctl.load_last;
    end else if (ctl.shift) begin
      data <= up.data;
      last <= up.last;
    end
  end

  assign slot.valid = valid;
  assign slot.last  = last;
  assign slot.data  = data;

endmodule

FILE: hw/rtl/delta_sign_group_encoder.sv
// ----------------------------------------------------------------------------
// delta_sign_group_encoder
// Packet byte delta encoder: first byte raw, then groups of a flag byte
// followed by up to GROUP_SIZE magnitude bytes.
// ----------------------------------------------------------------------------
//  channel | handshake                 | payload
//  --------+---------------------------+--------------------------------
//  item    | item_valid / item_stall   | data_byte, end_of_packet
//  code    | code_valid / code_stall   | coded_byte, coded_last
//
// a middle byte that emits nothing is never stalled; while code_stall is low
// the chain sends one coded byte per cycle; a full group is GROUP_SIZE+1 bytes.
// a byte that emits a group (or a first byte) waits until the output chain
// of GROUP_SIZE+1 cells has drained, then loads it in parallel.
// rst is synchronous and empties the chain; no clearing pass is needed.
// a stalled code transaction holds the chain; input keeps filling the group.
module delta_sign_group_encoder #(
  parameter int GROUP_SIZE = dsge_pkg::GROUP_SIZE_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_stall,
  input  dsge_pkg::item_t item,
  output logic            code_valid,
  input  logic            code_stall,
  output dsge_pkg::code_t code
);

  localparam int CW = $clog2(GROUP_SIZE + 1);
  localparam int BW = dsge_pkg::BYTE_W;

  logic [BW-1:0]         last_raw;
  logic                  in_packet;
  logic [CW-1:0]         count;
  logic [GROUP_SIZE-1:0] flags;

  logic [BW-1:0]         mag;
  logic                  inc;
  logic [CW-1:0]         count_inc;
  logic                  group_full;
  logic                  emit;
  logic                  drain_empty;
  logic                  accept;
  logic                  load;
  logic                  shift;
  logic [GROUP_SIZE-1:0] flags_next;

  dsge_pkg::cell_ctl_t   ctl [0:GROUP_SIZE];
  logic [BW-1:0]         alt [0:GROUP_SIZE];
  dsge_pkg::slot_t       slot [0:GROUP_SIZE+1];

  assign inc        = item.data_byte > last_raw;
  assign mag        = inc ? item.data_byte - last_raw : last_raw - item.data_byte;
  assign count_inc  = count + CW'(1);
  assign group_full = count_inc == CW'(GROUP_SIZE);
  assign emit       = in_packet ? (item.end_of_packet || group_full) : 1'b1;

  assign drain_empty = !slot[0].valid;
  assign item_stall  = emit && !drain_empty;
  assign accept      = item_valid && !item_stall;
  assign load        = accept && emit;
  assign shift       = slot[0].valid && !code_stall;

  always_comb begin
    for (int j = 0; j < GROUP_SIZE; j++) begin
      flags_next[j] = flags[j] | (inc && count == CW'(j));
    end
  end

  // per-cell load pattern
  always_comb begin
    for (int i = 0; i <= GROUP_SIZE; i++) begin
      ctl[i].load  = load;
      ctl[i].shift = shift;
      if (i == 0) begin
        ctl[i].capture    = 1'b0;
        ctl[i].use_alt    = 1'b1;
        ctl[i].load_valid = 1'b1;
        ctl[i].load_last  = 1'b0;
        alt[i]            = in_packet ? BW'(flags_next) : item.data_byte;
      end else if (in_packet) begin
        ctl[i].capture    = accept && count_inc == CW'(i);
        ctl[i].use_alt    = count_inc == CW'(i);
        ctl[i].load_valid = CW'(i) <= count_inc;
        ctl[i].load_last  = item.end_of_packet && count_inc == CW'(i);
        alt[i]            = mag;
      end else begin
        // first byte: a lone byte packet also gets an empty flag byte
        ctl[i].capture    = 1'b0;
        ctl[i].use_alt    = 1'b1;
        ctl[i].load_valid = (i == 1) && item.end_of_packet;
        ctl[i].load_last  = 1'b1;
        alt[i]            = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_raw  <= '0;
      in_packet <= 1'b0;
      count     <= '0;
      flags     <= '0;
    end else if (accept) begin
      last_raw  <= item.data_byte;
      in_packet <= !item.end_of_packet;
      if (!in_packet || emit) begin
        count <= '0;
        flags <= '0;
      end else begin
        count <= count_inc;
        flags <= flags_next;
      end
    end
  end

  assign slot[GROUP_SIZE+1] = '0;

  for (genvar g = 0; g <= GROUP_SIZE; g++) begin : g_cell
    dsge_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl[g]),
      .delta_in (mag),
      .alt_byte (alt[g]),
      .up       (slot[g+1]),
      .slot     (slot[g])
    );
  end

  assign code_valid      = slot[0].valid;
  assign code.coded_byte = slot[0].data;
  assign code.coded_last = slot[0].last;

endmodule

FILE: hw/rtl/dsge_checker.sv
// ----------------------------------------------------------------------------
// dsge_checker
// Port-level checks for the delta encoder, bound to the top level.
// ----------------------------------------------------------------------------
module dsge_checker (
  input logic            clk,
  input logic            rst,
  input logic            item_valid,
  input logic            item_stall,
  input dsge_pkg::item_t item,
  input logic            code_valid,
  input logic            code_stall,
  input dsge_pkg::code_t code
);

  a_code_hold_valid : assert property (@(posedge clk) disable iff (rst)
    code_valid && code_stall |=> code_valid)
    else $error("code_valid dropped while stalled");

  a_code_hold_data : assert property (@(posedge clk) disable iff (rst)
    code_valid && code_stall |=> $stable(code))
    else $error("code payload changed while stalled");

  a_reset_empty : assert property (@(posedge clk)
    rst |=> !code_valid)
    else $error("output not empty after reset");

  // an end of packet always loads the output chain at once
  a_eop_emits : assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && item.end_of_packet |=> code_valid)
    else $error("end of packet produced no output");

endmodule

bind delta_sign_group_encoder dsge_checker u_dsge_checker (
  .clk        (clk),
  .rst        (rst),
  .item_valid (item_valid),
  .item_stall (item_stall),
  .item       (item),
  .code_valid (code_valid),
  .code_stall (code_stall),
  .code       (code)
);

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the packet byte delta encoder. A driver feeds raw
// packet bytes with random gaps, an internal encoder model predicts the coded
// bytes, and a monitor with random stalls checks each coded transaction in
// order against the prediction.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GROUP_SIZE = dsge_pkg::GROUP_SIZE_DEF;
  localparam int TAIL_ITEMS = 30;

  typedef struct {
    dsge_pkg::item_t it;
    bit              drain;
  } pending_t;

  logic            clk;
  logic            rst = 1'b1;
  logic            item_valid = 1'b0;
  logic            item_stall;
  dsge_pkg::item_t item = '0;
  logic            code_valid;
  logic            code_stall = 1'b0;
  dsge_pkg::code_t code;

  pending_t        byte_queue[$];
  dsge_pkg::code_t coded_expect[$];

  // encoder model state
  logic [7:0] last_raw;
  bit         in_pkt;
  int         grp_cnt;
  logic [7:0] sign_bits;
  logic [7:0] mag_store [0:7];

  int   errors = 0;
  int   sent_cnt = 0;
  int   got_cnt = 0;
  int   mid_groups = 0;
  int   packets = 0;
  int   longest = 0;
  int   tx_gap = 0;
  int   rx_gap = 0;
  int   hold_left = 0;
  bit   hold_done = 0;
  logic long_hold = 1'b0;
  logic nxt_valid;
  dsge_pkg::item_t nxt_item;
  pending_t        nxt_pend;
  dsge_pkg::code_t want;

  delta_sign_group_encoder #(
    .GROUP_SIZE(GROUP_SIZE)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item      (item),
    .code_valid(code_valid),
    .code_stall(code_stall),
    .code      (code)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic flush_group(input bit last);
    dsge_pkg::code_t c;
    c.coded_byte = sign_bits;
    c.coded_last = last && (grp_cnt == 0);
    coded_expect = {coded_expect, c};
    for (int k = 0; k < grp_cnt; k++) begin
      c.coded_byte = mag_store[k];
      c.coded_last = last && (k == grp_cnt - 1);
      coded_expect = {coded_expect, c};
    end
    grp_cnt   = 0;
    sign_bits = '0;
  endtask

  task automatic encode_byte(input dsge_pkg::item_t it);
    dsge_pkg::code_t c;
    bit              rising;
    logic [7:0]      mag;
    if (!in_pkt) begin
      c.coded_byte = it.data_byte;
      c.coded_last = 1'b0;
      coded_expect = {coded_expect, c};
      last_raw  = it.data_byte;
      grp_cnt   = 0;
      sign_bits = '0;
      if (it.end_of_packet) begin
        flush_group(1'b1);
      end else begin
        in_pkt = 1'b1;
      end
    end else begin
      rising = it.data_byte > last_raw;
      mag = rising ? it.data_byte - last_raw : last_raw - it.data_byte;
      mag_store[grp_cnt] = mag;
      if (rising) begin
        sign_bits[grp_cnt] = 1'b1;
      end
      grp_cnt++;
      last_raw = it.data_byte;
      if (it.end_of_packet) begin
        flush_group(1'b1);
        in_pkt = 1'b0;
      end else if (grp_cnt >= GROUP_SIZE) begin
        flush_group(1'b0);
        mid_groups++;
      end
    end
  endtask

  task automatic add_byte(input logic [7:0] b, input bit eop, input bit drain);
    pending_t p;
    p.it.data_byte     = b;
    p.it.end_of_packet = eop;
    p.drain            = drain;
    byte_queue = {byte_queue, p};
  endtask

  // driver: offers pending bytes, holds a stalled transaction steady
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      item       <= '0;
      tx_gap = 0;
    end else begin
      nxt_valid = item_valid;
      nxt_item  = item;
      if (item_valid && !item_stall) begin
        encode_byte(item);
        sent_cnt++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (byte_queue.size() != 0) begin
          if (byte_queue.size() > TAIL_ITEMS && (sent_cnt % 100) < 70 &&
              $urandom_range(0, 5) == 0) begin
            tx_gap = $urandom_range(1, 12);
          end else if (!byte_queue[0].drain || coded_expect.size() == 0) begin
            nxt_pend  = byte_queue.pop_front();
            nxt_item  = nxt_pend.it;
            nxt_valid = 1'b1;
          end
        end
      end
      item_valid <= nxt_valid;
      item       <= nxt_item;
    end
  end

  // one long receiver hold-off so the group buffer backs up into the input
  always @(posedge clk) begin
    if (rst) begin
      long_hold <= 1'b0;
      hold_left = 0;
      hold_done = 0;
    end else if (hold_left > 0) begin
      hold_left--;
      if (hold_left == 0) begin
        long_hold <= 1'b0;
      end
    end else if (!hold_done && sent_cnt >= 60) begin
      hold_done = 1;
      hold_left = 200;
      long_hold <= 1'b1;
    end
  end

  // monitor: checks each coded transaction against the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      code_stall <= 1'b0;
      rx_gap = 0;
    end else begin
      if (code_valid && !code_stall) begin
        if (coded_expect.size() == 0) begin
          errors++;
          $display("%0t: unexpected coded byte: expected none, actual %02h last %0b",
                   $time, code.coded_byte, code.coded_last);
        end else begin
          want = coded_expect.pop_front();
          got_cnt++;
          if (code.coded_byte !== want.coded_byte) begin
            errors++;
            $display("%0t: coded_byte expected %02h actual %02h",
                     $time, want.coded_byte, code.coded_byte);
          end
          if (code.coded_last !== want.coded_last) begin
            errors++;
            $display("%0t: coded_last expected %0b actual %0b",
                     $time, want.coded_last, code.coded_last);
          end
        end
      end
      if (rx_gap > 0) begin
        rx_gap--;
      end else if (byte_queue.size() > TAIL_ITEMS && (sent_cnt % 100) >= 20 &&
                   $urandom_range(0, 6) == 0) begin
        rx_gap = $urandom_range(1, 12);
      end
      code_stall <= (rx_gap > 0) || long_hold;
    end
  end

  initial begin
    int         len;
    int         pick;
    int         style;
    int         total;
    logic [7:0] b;

    last_raw  = '0;
    in_pkt    = 1'b0;
    grp_cnt   = 0;
    sign_bits = '0;
    for (int k = 0; k < 8; k++) begin
      mag_store[k] = '0;
    end

    // single-byte packets at both extremes
    add_byte(8'h00, 1'b1, 1'b0);
    add_byte(8'hff, 1'b1, 1'b0);
    // full-scale rise, full-scale fall, equal bytes, mid rise
    add_byte(8'h00, 1'b0, 1'b0);
    add_byte(8'hff, 1'b0, 1'b0);
    add_byte(8'h00, 1'b0, 1'b0);
    add_byte(8'h00, 1'b0, 1'b0);
    add_byte(8'h80, 1'b1, 1'b0);
    // full group mid-packet, then one more delta closing the packet
    for (int k = 0; k < 10; k++) begin
      add_byte(8'($urandom), k == 9, 1'b0);
    end
    // group fills exactly on the last byte
    for (int k = 0; k < 9; k++) begin
      add_byte(8'($urandom), k == 8, 1'b0);
    end
    packets = 5;
    longest = 10;

    b = '0;
    while (byte_queue.size() < 230) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        len = $urandom_range(1, 12);
      end else if (pick < 8) begin
        len = $urandom_range(13, 30);
      end else begin
        len = GROUP_SIZE * $urandom_range(1, 3) + $urandom_range(0, 1) + 1;
      end
      style = $urandom_range(0, 3);
      for (int k = 0; k < len; k++) begin
        case (style)
          0: begin
            b = 8'($urandom);
          end
          1: begin
            b = b + 8'($urandom_range(0, 8)) - 8'd4;
          end
          2: begin
            b = ($urandom_range(0, 2) == 0) ? 8'($urandom) : b;
          end
          default: begin
            b = $urandom_range(0, 1) ? 8'hff : 8'h00;
          end
        endcase
        add_byte(b, k == len - 1, k == 0 && (packets == 8 || packets == 11));
      end
      packets++;
      if (len > longest) begin
        longest = len;
      end
    end
    total = byte_queue.size();

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (byte_queue.size() != 0 || item_valid) @(posedge clk);
    while (coded_expect.size() != 0) @(posedge clk);
    repeat (3 * (GROUP_SIZE + 1) + 10) @(posedge clk);

    $display("run covered %0d bytes in %0d packets (longest %0d), %0d coded bytes checked",
             total, packets, longest, got_cnt);
    $display("%0d groups closed mid-packet, one long receiver hold and two drain pauses",
             mid_groups);
    if (errors == 0) begin
      $display("delta_sign_group_encoder: match");
    end else begin
      $display("delta_sign_group_encoder: mismatch");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("delta_sign_group_encoder: mismatch");
    $finish;
  end

endmodule
